// ----- rtl/cpt_pkg.sv -----
// Shared constants and region codes for the closest-point-on-triangle block.
package cpt_pkg;

  // Default coordinate format: signed Q16.16
  localparam int COORD_BITS    = 32;
  localparam int FRACTION_BITS = 16;

  // Region code of a result beat
  typedef enum logic [2:0] {
    REG_INTERIOR = 3'd0,
    REG_CORNER_A = 3'd1,
    REG_CORNER_C = 3'd2,
    REG_EDGE_AC  = 3'd3,
    REG_CORNER_B = 3'd4,
    REG_EDGE_AB  = 3'd5,
    REG_EDGE_BC  = 3'd6
  } region_t;

endpackage

// ----- rtl/cpt_delay.sv -----
// Delay line with a reset valid bit travelling beside its payload.
module cpt_delay #(
  parameter int W = 8,
  parameter int N = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         vld_in,
  input  logic [W-1:0] dat_in,
  output logic         vld_out,
  output logic [W-1:0] dat_out
);

  logic         vld_r [N];
  logic [W-1:0] dat_r [N];

  // Advance valid bits, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) vld_r[i] <= 1'b0;
    end else begin
      vld_r[0] <= vld_in;
      for (int i = 1; i < N; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    dat_r[0] <= dat_in;
    for (int i = 1; i < N; i++) dat_r[i] <= dat_r[i-1];
  end

  assign vld_out = vld_r[N-1];
  assign dat_out = dat_r[N-1];

endmodule

// ----- rtl/cpt_dot.sv -----
// Two-stage three-term dot product: products, then sum.
module cpt_dot #(
  parameter int D = cpt_pkg::COORD_BITS + 1
) (
  input  logic                    clk,
  input  logic signed [D-1:0]     x [3],
  input  logic signed [D-1:0]     y [3],
  output logic signed [2*D+1:0]   dot
);

  logic signed [2*D-1:0] prod_r [3];
  logic signed [2*D+1:0] dot_r;

  // Register each product
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) prod_r[k] <= x[k] * y[k];
  end

  // Sum the products
  always_ff @(posedge clk) begin
    dot_r <= (2*D+2)'(prod_r[0]) + (2*D+2)'(prod_r[1]) + (2*D+2)'(prod_r[2]);
  end

  assign dot = dot_r;

endmodule

// ----- rtl/cpt_div.sv -----
// Pipelined restoring divider: floor(num * 2^F / den), clamped to +/-2.0.
module cpt_div #(
  parameter int NW = 2 * cpt_pkg::COORD_BITS + 4,
  parameter int F  = cpt_pkg::FRACTION_BITS
) (
  input  logic                 clk,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic signed [F+2:0]  quo,
  output logic                 zero
);

  localparam int NS = F + 2;

  logic [NW:0]   rem_r  [NS];
  logic [NW-1:0] den_r  [NS];
  logic [F:0]    q_r    [NS];
  logic          neg_r  [NS];
  logic          zero_r [NS];
  logic          sat_r  [NS];

  logic [NW-1:0]        mag;
  logic signed [F+2:0]  quo_r;
  logic                 zero_out_r;

  // Take the magnitude of the numerator
  assign mag = num[NW-1] ? (~num + 1'b1) : num;

  // Prepare: magnitude, zero divisor, out-of-range check
  always_ff @(posedge clk) begin
    rem_r[0]  <= {1'b0, mag};
    den_r[0]  <= den;
    q_r[0]    <= '0;
    neg_r[0]  <= num[NW-1];
    zero_r[0] <= (den == '0);
    sat_r[0]  <= {1'b0, mag} >= {den, 1'b0};
  end

  // One quotient bit per stage
  for (genvar i = 0; i <= F; i++) begin : g_bit
    logic [NW:0] sh;
    logic        ge;
    assign sh = (i == 0) ? rem_r[i] : {rem_r[i][NW-1:0], 1'b0};
    assign ge = sh >= {1'b0, den_r[i]};
    always_ff @(posedge clk) begin
      rem_r[i+1]  <= ge ? (sh - {1'b0, den_r[i]}) : sh;
      den_r[i+1]  <= den_r[i];
      q_r[i+1]    <= {q_r[i][F-1:0], ge};
      neg_r[i+1]  <= neg_r[i];
      zero_r[i+1] <= zero_r[i];
      sat_r[i+1]  <= sat_r[i];
    end
  end

  // Apply sign, floor correction, clamp and zero divisor
  always_ff @(posedge clk) begin
    priority if (zero_r[NS-1]) begin
      quo_r <= '0;
    end else if (sat_r[NS-1]) begin
      quo_r <= neg_r[NS-1] ? -$signed({2'b01, {(F+1){1'b0}}})
                           :  $signed({2'b01, {(F+1){1'b0}}});
    end else if (neg_r[NS-1]) begin
      quo_r <= -$signed({2'b00, q_r[NS-1]} + (F+3)'(rem_r[NS-1] != '0));
    end else begin
      quo_r <= $signed({2'b00, q_r[NS-1]});
    end
    zero_out_r <= zero_r[NS-1];
  end

  assign quo  = quo_r;
  assign zero = zero_out_r;

endmodule

// ----- rtl/cpt_comb.sv -----
// Two-stage point update: base + round(qa*ra + qb*rb), saturated.
module cpt_comb #(
  parameter int C = cpt_pkg::COORD_BITS,
  parameter int F = cpt_pkg::FRACTION_BITS
) (
  input  logic                clk,
  input  logic signed [C-1:0] base,
  input  logic signed [F+2:0] qa,
  input  logic signed [C:0]   ra,
  input  logic signed [F+2:0] qb,
  input  logic signed [C:0]   rb,
  output logic signed [C-1:0] img
);

  localparam int PW = F + 3 + C + 1;
  localparam int SW = PW + 1;
  localparam int TW = SW - F;
  localparam int YW = TW + 1;
  localparam logic signed [SW-1:0] HALF = {{(SW-F){1'b0}}, 1'b1, {(F-1){1'b0}}};
  localparam logic signed [YW-1:0] MAXV = {{(YW-C+1){1'b0}}, {(C-1){1'b1}}};
  localparam logic signed [YW-1:0] MINV = {{(YW-C+1){1'b1}}, {(C-1){1'b0}}};

  logic signed [PW-1:0] pa_r, pb_r;
  logic signed [C-1:0]  base_r, img_r;
  logic signed [SW-1:0] sum;
  logic signed [YW-1:0] y;

  // Register the two products
  always_ff @(posedge clk) begin
    pa_r   <= qa * ra;
    pb_r   <= qb * rb;
    base_r <= base;
  end

  // Round to nearest, add the base corner, saturate
  assign sum = SW'(pa_r) + SW'(pb_r) + HALF;
  assign y   = YW'(base_r) + YW'(sum >>> F);

  always_ff @(posedge clk) begin
    priority if (y > MAXV) img_r <= MAXV[C-1:0];
    else if (y < MINV)     img_r <= MINV[C-1:0];
    else                   img_r <= y[C-1:0];
  end

  assign img = img_r;

endmodule

// ----- rtl/closest_point_on_triangle.sv -----
// Throughput: one item per cycle; busy stays low, the pipeline never stalls.
// The depth is set by the bit-per-stage quotient pipelines, FRACTION_BITS + 3 stages.
// Reset (rst_n low, synchronous) clears all valid bits; no result beat follows it.
// The receiver cannot stall: each result beat is on the out_ ports for one cycle.
// Top level: closest point on a triangle to a query point, fully pipelined.
module closest_point_on_triangle #(
  parameter int COORD_BITS    = cpt_pkg::COORD_BITS,
  parameter int FRACTION_BITS = cpt_pkg::FRACTION_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_corner_a_x,
  input  logic signed [COORD_BITS-1:0] in_corner_a_y,
  input  logic signed [COORD_BITS-1:0] in_corner_a_z,
  input  logic signed [COORD_BITS-1:0] in_corner_b_x,
  input  logic signed [COORD_BITS-1:0] in_corner_b_y,
  input  logic signed [COORD_BITS-1:0] in_corner_b_z,
  input  logic signed [COORD_BITS-1:0] in_corner_c_x,
  input  logic signed [COORD_BITS-1:0] in_corner_c_y,
  input  logic signed [COORD_BITS-1:0] in_corner_c_z,
  input  logic signed [COORD_BITS-1:0] in_query_x,
  input  logic signed [COORD_BITS-1:0] in_query_y,
  input  logic signed [COORD_BITS-1:0] in_query_z,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_image_x,
  output logic signed [COORD_BITS-1:0] out_image_y,
  output logic signed [COORD_BITS-1:0] out_image_z,
  output logic [2:0]                   out_region,
  output logic                         out_degenerate
);

  localparam int C      = COORD_BITS;
  localparam int F      = FRACTION_BITS;
  localparam int D      = C + 1;
  localparam int DW     = 2 * D + 2;
  localparam int QW     = F + 3;
  localparam int SIDE_N = 2 + F + 3;
  localparam int LAT    = F + 9;
  localparam logic signed [QW-1:0] ONE = {2'b00, 1'b1, {F{1'b0}}};

  typedef struct packed {
    logic [2:0][C-1:0] a;
    logic [2:0][C-1:0] b;
    logic [2:0][C-1:0] c;
    logic [2:0][D-1:0] r1;
    logic [2:0][D-1:0] r2;
    logic [2:0][D-1:0] v;
  } side_t;

  typedef struct packed {
    logic [2:0] region;
    logic       deg;
  } tag_t;

  logic signed [C-1:0] a_in [3], b_in [3], c_in [3], p_in [3];
  logic signed [C-1:0] a_r [3], b_r [3], c_r [3];
  logic signed [D-1:0] r0_r [3], r1_r [3], r2_r [3], u_r [3], v_r [3];
  logic                vld0_r;

  logic signed [DW-1:0] n1, d1, n2, d2, n3, d3;
  logic signed [QW-1:0] q1, q2, lam;
  logic                 z1, z2, z3;

  side_t side_in, side_out;
  logic  vld_side;

  // The pipeline never stalls
  assign busy = 1'b0;

  assign a_in = '{in_corner_a_x, in_corner_a_y, in_corner_a_z};
  assign b_in = '{in_corner_b_x, in_corner_b_y, in_corner_b_z};
  assign c_in = '{in_corner_c_x, in_corner_c_y, in_corner_c_z};
  assign p_in = '{in_query_x, in_query_y, in_query_z};

  // Stage 0: capture corners and form edge and offset vectors
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      a_r[k]  <= a_in[k];
      b_r[k]  <= b_in[k];
      c_r[k]  <= c_in[k];
      r0_r[k] <= D'(p_in[k]) - D'(a_in[k]);
      r1_r[k] <= D'(b_in[k]) - D'(a_in[k]);
      r2_r[k] <= D'(c_in[k]) - D'(a_in[k]);
      u_r[k]  <= D'(p_in[k]) - D'(b_in[k]);
      v_r[k]  <= D'(c_in[k]) - D'(b_in[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vld0_r <= 1'b0;
    else        vld0_r <= start & ~busy;
  end

  // Dot products for the three projections
  cpt_dot #(.D(D)) u_dot_n1 (.clk(clk), .x(r1_r), .y(r0_r), .dot(n1));
  cpt_dot #(.D(D)) u_dot_d1 (.clk(clk), .x(r1_r), .y(r1_r), .dot(d1));
  cpt_dot #(.D(D)) u_dot_n2 (.clk(clk), .x(r2_r), .y(r0_r), .dot(n2));
  cpt_dot #(.D(D)) u_dot_d2 (.clk(clk), .x(r2_r), .y(r2_r), .dot(d2));
  cpt_dot #(.D(D)) u_dot_n3 (.clk(clk), .x(v_r),  .y(u_r),  .dot(n3));
  cpt_dot #(.D(D)) u_dot_d3 (.clk(clk), .x(v_r),  .y(v_r),  .dot(d3));

  // Quotients
  cpt_div #(.NW(DW), .F(F)) u_div_1 (.clk(clk), .num(n1), .den(d1), .quo(q1),  .zero(z1));
  cpt_div #(.NW(DW), .F(F)) u_div_2 (.clk(clk), .num(n2), .den(d2), .quo(q2),  .zero(z2));
  cpt_div #(.NW(DW), .F(F)) u_div_3 (.clk(clk), .num(n3), .den(d3), .quo(lam), .zero(z3));

  // Carry corners and vectors alongside the arithmetic
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      side_in.a[k]  = a_r[k];
      side_in.b[k]  = b_r[k];
      side_in.c[k]  = c_r[k];
      side_in.r1[k] = r1_r[k];
      side_in.r2[k] = r2_r[k];
      side_in.v[k]  = v_r[k];
    end
  end

  cpt_delay #(.W($bits(side_t)), .N(SIDE_N)) u_side (
    .clk(clk), .rst_n(rst_n), .vld_in(vld0_r), .dat_in(side_in),
    .vld_out(vld_side), .dat_out(side_out)
  );

  // Region decision
  logic signed [QW:0]   qsum;
  logic [2:0]           region;
  logic                 bc;
  logic signed [C-1:0]  base [3];
  logic signed [QW-1:0] qa, qb;
  logic signed [D-1:0]  ra [3], rb [3];

  assign qsum = (QW+1)'(q1) + (QW+1)'(q2);

  always_comb begin
    region = cpt_pkg::REG_INTERIOR;
    bc     = 1'b0;
    qa     = '0;
    qb     = '0;
    for (int k = 0; k < 3; k++) begin
      base[k] = $signed(side_out.a[k]);
      ra[k]   = $signed(side_out.r1[k]);
      rb[k]   = $signed(side_out.r2[k]);
    end
    priority if (q1 > 0 && q2 > 0 && qsum < (QW+1)'(ONE)) begin
      region = cpt_pkg::REG_INTERIOR;
      qa     = q1;
      qb     = q2;
    end else if (q1 < 0) begin
      priority if (q2 < 0) begin
        region = cpt_pkg::REG_CORNER_A;
      end else if (q2 > ONE) begin
        region = cpt_pkg::REG_CORNER_C;
        for (int k = 0; k < 3; k++) base[k] = $signed(side_out.c[k]);
      end else begin
        region = cpt_pkg::REG_EDGE_AC;
        qa     = q2;
        for (int k = 0; k < 3; k++) ra[k] = $signed(side_out.r2[k]);
      end
    end else if (q2 < 0) begin
      priority if (q1 > ONE) begin
        region = cpt_pkg::REG_CORNER_B;
        for (int k = 0; k < 3; k++) base[k] = $signed(side_out.b[k]);
      end else begin
        region = cpt_pkg::REG_EDGE_AB;
        qa     = q1;
      end
    end else begin
      bc = 1'b1;
      priority if (lam < 0) begin
        region = cpt_pkg::REG_CORNER_B;
        for (int k = 0; k < 3; k++) base[k] = $signed(side_out.b[k]);
      end else if (lam < ONE) begin
        region = cpt_pkg::REG_EDGE_BC;
        qa     = lam;
        for (int k = 0; k < 3; k++) begin
          base[k] = $signed(side_out.b[k]);
          ra[k]   = $signed(side_out.v[k]);
        end
      end else begin
        region = cpt_pkg::REG_CORNER_C;
        for (int k = 0; k < 3; k++) base[k] = $signed(side_out.c[k]);
      end
    end
  end

  // Register the selection
  logic signed [C-1:0]  base_r [3];
  logic signed [QW-1:0] qa_r, qb_r;
  logic signed [D-1:0]  ra_r [3], rb_r [3];
  tag_t                 tag_r, tag_out;
  logic                 vdec_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      base_r[k] <= base[k];
      ra_r[k]   <= ra[k];
      rb_r[k]   <= rb[k];
    end
    qa_r         <= qa;
    qb_r         <= qb;
    tag_r.region <= region;
    tag_r.deg    <= z1 | z2 | (bc & z3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vdec_r <= 1'b0;
    else        vdec_r <= vld_side;
  end

  // Point update per axis
  logic signed [C-1:0] img [3];

  for (genvar k = 0; k < 3; k++) begin : g_axis
    cpt_comb #(.C(C), .F(F)) u_comb (
      .clk(clk), .base(base_r[k]), .qa(qa_r), .ra(ra_r[k]),
      .qb(qb_r), .rb(rb_r[k]), .img(img[k])
    );
  end

  // Hold region and flag beside the point update
  cpt_delay #(.W($bits(tag_t)), .N(2)) u_tag (
    .clk(clk), .rst_n(rst_n), .vld_in(vdec_r), .dat_in(tag_r),
    .vld_out(out_valid), .dat_out(tag_out)
  );

  assign out_image_x    = img[0];
  assign out_image_y    = img[1];
  assign out_image_z    = img[2];
  assign out_region     = tag_out.region;
  assign out_degenerate = tag_out.deg;

  // Every accepted beat yields a result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("result beat missing");

  // No result beat without an accepted item
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LAT))
    else $error("spurious result beat");

  // Corner A region returns corner A unchanged; the x and z axes are checked
  a_corner_a: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_region == cpt_pkg::REG_CORNER_A) |->
      (out_image_x == $past(in_corner_a_x, LAT) && out_image_z == $past(in_corner_a_z, LAT)))
    else $error("corner A image mismatch");

  // Interior needs both projections positive, so no zero divisor
  a_interior: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_region == cpt_pkg::REG_INTERIOR) |-> !out_degenerate)
    else $error("degenerate interior result");

endmodule

// ----- tb/closest_point_on_triangle_chk.sv -----
// Checker for the closest-point block: predicts each result beat and compares it on arrival.
module closest_point_on_triangle_chk (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic signed [31:0] in_corner_a_x,
  input  logic signed [31:0] in_corner_a_y,
  input  logic signed [31:0] in_corner_a_z,
  input  logic signed [31:0] in_corner_b_x,
  input  logic signed [31:0] in_corner_b_y,
  input  logic signed [31:0] in_corner_b_z,
  input  logic signed [31:0] in_corner_c_x,
  input  logic signed [31:0] in_corner_c_y,
  input  logic signed [31:0] in_corner_c_z,
  input  logic signed [31:0] in_query_x,
  input  logic signed [31:0] in_query_y,
  input  logic signed [31:0] in_query_z,
  input  logic               out_valid,
  input  logic signed [31:0] out_image_x,
  input  logic signed [31:0] out_image_y,
  input  logic signed [31:0] out_image_z,
  input  logic [2:0]         out_region,
  input  logic               out_degenerate,
  output int                 fails,
  output int                 pending
);

  typedef logic signed [127:0] wide_t;
  typedef wide_t vec_t [3];

  typedef struct {
    logic signed [31:0] img [3];
    cpt_pkg::region_t   region;
    logic               degenerate;
  } image_t;

  image_t images_due [$];

  assign pending = images_due.size();

  function automatic wide_t dot3(input vec_t u, input vec_t v);
    return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
  endfunction

  // Floor of num * 2^F / den, clamped to +-2.0; zero divisor gives 0 and raises the flag
  function automatic wide_t ratio(input wide_t num, input wide_t den, inout logic zero);
    wide_t mag, qm, rem, lim;
    logic  neg;
    lim = wide_t'(1) <<< (cpt_pkg::FRACTION_BITS + 1);
    if (den == 0) begin
      zero = 1'b1;
      return 0;
    end
    neg = num < 0;
    mag = neg ? -num : num;
    if (mag >= den * 2) return neg ? -lim : lim;
    qm  = (mag <<< cpt_pkg::FRACTION_BITS) / den;
    rem = (mag <<< cpt_pkg::FRACTION_BITS) - qm * den;
    if (neg) return -(qm + ((rem != 0) ? 1 : 0));
    return qm;
  endfunction

  // Base plus rounded weighted edge sum (ties upward), saturated to the coordinate range
  function automatic logic signed [31:0] place(input wide_t base, input wide_t qa,
                                               input wide_t ra, input wide_t qb,
                                               input wide_t rb);
    wide_t s, t;
    s = qa * ra + qb * rb + (wide_t'(1) <<< (cpt_pkg::FRACTION_BITS - 1));
    t = base + (s >>> cpt_pkg::FRACTION_BITS);
    if (t > wide_t'(32'sh7FFF_FFFF)) return 32'sh7FFF_FFFF;
    if (t < wide_t'(32'sh8000_0000)) return 32'sh8000_0000;
    return t[31:0];
  endfunction

  function automatic image_t closest(input vec_t a, input vec_t b, input vec_t c,
                                     input vec_t p);
    vec_t   r0, r1, r2, u, v;
    wide_t  q1, q2, lam, one;
    image_t e;
    logic   deg;
    deg = 1'b0;
    one = wide_t'(1) <<< cpt_pkg::FRACTION_BITS;
    for (int k = 0; k < 3; k++) begin
      r0[k] = p[k] - a[k];
      r1[k] = b[k] - a[k];
      r2[k] = c[k] - a[k];
      u[k]  = p[k] - b[k];
      v[k]  = c[k] - b[k];
    end
    q1 = ratio(dot3(r1, r0), dot3(r1, r1), deg);
    q2 = ratio(dot3(r2, r0), dot3(r2, r2), deg);
    if (q1 > 0 && q2 > 0 && q1 + q2 < one) begin
      e.region = cpt_pkg::REG_INTERIOR;
      for (int k = 0; k < 3; k++) e.img[k] = place(a[k], q1, r1[k], q2, r2[k]);
    end else if (q1 < 0) begin
      if (q2 < 0) begin
        e.region = cpt_pkg::REG_CORNER_A;
        for (int k = 0; k < 3; k++) e.img[k] = a[k][31:0];
      end else if (q2 > one) begin
        e.region = cpt_pkg::REG_CORNER_C;
        for (int k = 0; k < 3; k++) e.img[k] = c[k][31:0];
      end else begin
        e.region = cpt_pkg::REG_EDGE_AC;
        for (int k = 0; k < 3; k++) e.img[k] = place(a[k], q2, r2[k], 0, 0);
      end
    end else if (q2 < 0) begin
      if (q1 > one) begin
        e.region = cpt_pkg::REG_CORNER_B;
        for (int k = 0; k < 3; k++) e.img[k] = b[k][31:0];
      end else begin
        e.region = cpt_pkg::REG_EDGE_AB;
        for (int k = 0; k < 3; k++) e.img[k] = place(a[k], q1, r1[k], 0, 0);
      end
    end else begin
      // Project onto edge BC, measured from B toward C
      lam = ratio(dot3(v, u), dot3(v, v), deg);
      if (lam < 0) begin
        e.region = cpt_pkg::REG_CORNER_B;
        for (int k = 0; k < 3; k++) e.img[k] = b[k][31:0];
      end else if (lam < one) begin
        e.region = cpt_pkg::REG_EDGE_BC;
        for (int k = 0; k < 3; k++) e.img[k] = place(b[k], lam, v[k], 0, 0);
      end else begin
        e.region = cpt_pkg::REG_CORNER_C;
        for (int k = 0; k < 3; k++) e.img[k] = c[k][31:0];
      end
    end
    e.degenerate = deg;
    return e;
  endfunction

  // Queue a prediction per accepted beat; compare each result beat with the oldest one
  always @(posedge clk) begin
    image_t e;
    vec_t   a, b, c, p;
    if (!rst_n) begin
      fails = 0;
    end else begin
      if (start && !busy) begin
        a = '{in_corner_a_x, in_corner_a_y, in_corner_a_z};
        b = '{in_corner_b_x, in_corner_b_y, in_corner_b_z};
        c = '{in_corner_c_x, in_corner_c_y, in_corner_c_z};
        p = '{in_query_x, in_query_y, in_query_z};
        images_due.insert(images_due.size(), closest(a, b, c, p));
      end
      if (out_valid) begin
        if (images_due.size() == 0) begin
          $error("result beat with no prediction waiting");
          fails++;
        end else begin
          e = images_due.pop_front();
          if (out_image_x !== e.img[0]) begin
            $error("image_x: expected %0d, got %0d", e.img[0], out_image_x);
            fails++;
          end
          if (out_image_y !== e.img[1]) begin
            $error("image_y: expected %0d, got %0d", e.img[1], out_image_y);
            fails++;
          end
          if (out_image_z !== e.img[2]) begin
            $error("image_z: expected %0d, got %0d", e.img[2], out_image_z);
            fails++;
          end
          if (out_region !== e.region) begin
            $error("region: expected %0d, got %0d", e.region, out_region);
            fails++;
          end
          if (out_degenerate !== e.degenerate) begin
            $error("degenerate: expected %0d, got %0d", e.degenerate, out_degenerate);
            fails++;
          end
        end
      end
    end
  end

endmodule

// ----- tb/closest_point_on_triangle_tb.sv -----
// Stimulus and verdict for the closest-point-on-triangle block.
module closest_point_on_triangle_tb;

  localparam int U         = 65536;
  localparam int N_RANDOM  = 1835;
  localparam int LIMIT     = 400000;

  typedef logic signed [31:0] coord_t;

  logic   clk;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  logic   busy;
  coord_t drv [12] = '{default: '0};
  logic   out_valid;
  coord_t out_image_x, out_image_y, out_image_z;
  logic [2:0] out_region;
  logic   out_degenerate;
  int     fails, pending;
  int     idle_pct = 10;
  int     cycles = 0;

  closest_point_on_triangle u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_corner_a_x(drv[0]), .in_corner_a_y(drv[1]), .in_corner_a_z(drv[2]),
    .in_corner_b_x(drv[3]), .in_corner_b_y(drv[4]), .in_corner_b_z(drv[5]),
    .in_corner_c_x(drv[6]), .in_corner_c_y(drv[7]), .in_corner_c_z(drv[8]),
    .in_query_x(drv[9]), .in_query_y(drv[10]), .in_query_z(drv[11]),
    .out_valid(out_valid), .out_image_x(out_image_x), .out_image_y(out_image_y),
    .out_image_z(out_image_z), .out_region(out_region), .out_degenerate(out_degenerate)
  );

  closest_point_on_triangle_chk u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_corner_a_x(drv[0]), .in_corner_a_y(drv[1]), .in_corner_a_z(drv[2]),
    .in_corner_b_x(drv[3]), .in_corner_b_y(drv[4]), .in_corner_b_z(drv[5]),
    .in_corner_c_x(drv[6]), .in_corner_c_y(drv[7]), .in_corner_c_z(drv[8]),
    .in_query_x(drv[9]), .in_query_y(drv[10]), .in_query_z(drv[11]),
    .out_valid(out_valid), .out_image_x(out_image_x), .out_image_y(out_image_y),
    .out_image_z(out_image_z), .out_region(out_region), .out_degenerate(out_degenerate),
    .fails(fails), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("closest_point_on_triangle_tb NOT OK");
      $finish;
    end
  end

  // Idle a random number of cycles, then hold one beat until it is taken
  task automatic send_item(input coord_t v [12]);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int i = 0; i < 12; i++) drv[i] <= v[i];
    start <= 1'b1;
    do @(negedge clk); while (busy);
    @(posedge clk);
  endtask

  function automatic coord_t rand_coord(input int mode);
    case (mode)
      0: return $signed($urandom_range(16 * U)) - 8 * U;
      1: return $signed($urandom) >>> $urandom_range(4, 14);
      default: return $signed($urandom);
    endcase
  endfunction

  initial begin
    coord_t v [12];
    int     mode, pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every region, zero-length edges, coordinate extremes
    send_item('{0, 0, 0, 4*U, 0, 0, 0, 4*U, 0, U, U, 5*U});
    send_item('{0, 0, 0, 4*U, 0, 0, 0, 4*U, 0, -U, -U, 0});
    send_item('{0, 0, 0, 4*U, 0, 0, 0, 4*U, 0, -U, 6*U, 0});
    send_item('{0, 0, 0, 4*U, 0, 0, 0, 4*U, 0, -U, 2*U, 0});
    send_item('{0, 0, 0, 4*U, 0, 0, 0, 4*U, 0, 6*U, -U, 0});
    send_item('{0, 0, 0, 4*U, 0, 0, 0, 4*U, 0, 2*U, -U, 0});
    send_item('{0, 0, 0, 4*U, 0, 0, 0, 4*U, 0, 3*U, 3*U, 0});
    send_item('{0, 0, 0, 4*U, 0, 0, 0, 4*U, 0, U, 5*U, 0});
    send_item('{0, 0, 0, 4*U, 0, 0, 0, 4*U, 0, 6*U, 0, 0});
    send_item('{0, 0, 0, 4*U, 0, 0, 0, 4*U, 0, 5*U, U, 0});
    send_item('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
    send_item('{U, U, U, U, U, U, 3*U, -U, 2*U, 0, 5*U, -U});
    send_item('{0, 0, 0, 4*U, 0, 0, 4*U, 0, 0, 5*U, U, 0});
    send_item('{32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000,
                32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000,
                32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000});
    send_item('{default: 32'sh7FFFFFFF});
    send_item('{default: 32'sh80000000});
    send_item('{32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                32'sh80000000, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF});
    send_item('{32'sh80000000, 0, 0, 32'sh7FFFFFFF, 0, 0, 0, 32'sh7FFFFFFF, 0,
                32'sh7FFFFFFF, 32'sh7FFFFFFF, 0});

    // Random: half small triangles for region variety, some wide, some degenerate
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 600) idle_pct = 83;
      if (n == 1200) idle_pct = 0;
      pick = $urandom_range(99);
      mode = (pick < 50) ? 0 : (pick < 70) ? 1 : 2;
      for (int i = 0; i < 12; i++) v[i] = rand_coord(mode);
      if (pick >= 90) begin
        // Collapse one edge so a divisor is zero
        case ($urandom_range(2))
          0: for (int k = 0; k < 3; k++) v[3+k] = v[k];
          1: for (int k = 0; k < 3; k++) v[6+k] = v[k];
          default: for (int k = 0; k < 3; k++) v[6+k] = v[3+k];
        endcase
      end
      send_item(v);
    end
    start <= 1'b0;

    // Drain, then let the pipeline settle
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fails == 0) begin
      $display("closest_point_on_triangle_tb OK");
    end else begin
      $display("closest_point_on_triangle_tb NOT OK");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cpt_pkg.sv
rtl/cpt_delay.sv
rtl/cpt_dot.sv
rtl/cpt_div.sv
rtl/cpt_comb.sv
rtl/closest_point_on_triangle.sv
tb/closest_point_on_triangle_chk.sv
tb/closest_point_on_triangle_tb.sv
